FILE: rtl/sem_pkg.sv
// Shared widths, register indexes, types and the root step for the Sobel magnitude unit.
package sem_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int PIX_W       = 8;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int GRAD_W      = 10;
    localparam int SQ_W        = 2 * GRAD_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int REM_W       = 16;
    localparam int ROOT_W      = 8;
    localparam int ROOT_STAGES = ROOT_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 16'd3;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);

    // gradient magnitudes of one window, on their way to the root pipe
    typedef struct packed {
        logic              vld;
        logic [GRAD_W-1:0] ax;
        logic [GRAD_W-1:0] ay;
        logic              last;
    } t_grad;

    // partial root and remainder (operand minus root squared)
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_root_state;

    // one bit of a restoring square root: try root | 2^bitpos
    function automatic t_root_state root_step(input t_root_state s, input int unsigned bitpos);
        logic [REM_W:0] trial;
        t_root_state    res;
        trial = ({{(REM_W+1-ROOT_W){1'b0}}, s.root} << (bitpos + 1))
              + ((REM_W+1)'(1) << (2 * bitpos));
        res = s;
        if (trial <= {1'b0, s.rem}) begin
            res.root = s.root | (ROOT_W'(1) << bitpos);
            res.rem  = s.rem - trial[REM_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/sem_mag_pipe.sv
// Squaring, sum and eight-stage square root pipeline for the edge magnitude.
module sem_mag_pipe
    import sem_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  t_grad             i_grad,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_magnitude,
    output logic              o_last
);

    // squares
    logic              r_sq_vld;
    logic              r_sq_last;
    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;

    // sum, saturation flag
    logic              r_sum_vld;
    logic              r_sum_last;
    logic              r_sum_sat;
    logic [REM_W-1:0]  r_sum;

    // root stages
    logic              r_rt_vld  [0:ROOT_STAGES-1];
    logic              r_rt_last [0:ROOT_STAGES-1];
    logic              r_rt_sat  [0:ROOT_STAGES-1];
    t_root_state       r_rt      [0:ROOT_STAGES-1];

    logic [SUM_W-1:0]  sum_full;
    t_root_state       root_init;

    assign sum_full  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign root_init = '{root: '0, rem: r_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
            for (int k = 0; k < ROOT_STAGES; k++) begin
                r_rt_vld[k] <= 1'b0;
            end
        end else if (i_advance) begin
            r_sq_vld  <= i_grad.vld;
            r_sum_vld <= r_sq_vld;
            r_rt_vld[0] <= r_sum_vld;
            for (int k = 1; k < ROOT_STAGES; k++) begin
                r_rt_vld[k] <= r_rt_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_sqx      <= i_grad.ax * i_grad.ax;
            r_sqy      <= i_grad.ay * i_grad.ay;
            r_sq_last  <= i_grad.last;
            r_sum      <= sum_full[REM_W-1:0];
            r_sum_sat  <= |sum_full[SUM_W-1:REM_W];
            r_sum_last <= r_sq_last;
            r_rt[0]      <= root_step(root_init, ROOT_W - 1);
            r_rt_sat[0]  <= r_sum_sat;
            r_rt_last[0] <= r_sum_last;
            for (int k = 1; k < ROOT_STAGES; k++) begin
                r_rt[k]      <= root_step(r_rt[k-1], ROOT_W - 1 - k);
                r_rt_sat[k]  <= r_rt_sat[k-1];
                r_rt_last[k] <= r_rt_last[k-1];
            end
        end
    end

    assign o_valid     = r_rt_vld[ROOT_STAGES-1];
    assign o_last      = r_rt_last[ROOT_STAGES-1];
    assign o_magnitude = r_rt_sat[ROOT_STAGES-1] ? {ROOT_W{1'b1}}
                                                 : r_rt[ROOT_STAGES-1].root;

endmodule

FILE: rtl/sobel_edge_magnitude_3x3_unit.sv
// Streaming 3x3 Sobel edge magnitude unit: line memory, window, gradients, root pipe.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one pixel word in raster
//   order; i_frame_start puts that pixel at column 0, row 0. Output channel
//   (o_out_valid / i_out_stall) carries one magnitude word per interior pixel,
//   floor(sqrt(gx^2 + gy^2)) saturated at 255, o_last_of_frame on the last one.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 width,
//   1 height) at once; write only while the unit is idle.
// Pixel flow: the line memory is read at acceptance and written back when the
//   output is not stalled; the input is held off until that write-back
//   (interlock on the read-modify-write), so no forwarding is needed.
// Path: the pixel completing a window passes the memory read, gradient,
//   squares and sum registers and the 8 root stages before its result appears.
// Reset (i_rst_n low, synchronous): counters, window and config return to
//   their defaults, all valids clear. The line memory is not cleared; it is
//   always written in a frame before its contents reach a result.
// Receiver stall: the result pipe freezes while o_out_valid is high and
//   i_out_stall is asserted; one further pixel may be taken in, then the
//   input stalls until the output moves.
module sobel_edge_magnitude_3x3_unit
    import sem_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // pixel input
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PIX_W-1:0]       i_pixel,
    input  logic                   i_frame_start,
    // magnitude output
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [ROOT_W-1:0]      o_magnitude,
    output logic                   o_last_of_frame,
    // config writes
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // config
    logic [WIDTH_W-1:0]   r_cfg_width;
    logic [HEIGHT_W-1:0]  r_cfg_height;

    // position of the next pixel
    logic [COL_W-1:0]     r_col;
    logic [HEIGHT_W-1:0]  r_row;

    // pixel waiting for its memory read
    logic                 r_busy;
    logic [PIX_W-1:0]     r_px;
    logic [COL_W-1:0]     r_addr;
    logic                 r_emit;
    logic                 r_last;

    // line memory: {older row, newer row} per column
    logic [2*PIX_W-1:0]   r_line_mem [0:MAX_WIDTH-1];
    logic [2*PIX_W-1:0]   r_rd_data;

    // window, [row][column], row 2 and column 2 newest
    logic [PIX_W-1:0]     r_win [0:2][0:2];

    t_grad                r_grad;

    logic                 accept;
    logic                 advance;
    logic                 do_update;
    logic [WIDTH_W-1:0]   w_eff;
    logic [HEIGHT_W-1:0]  h_eff;
    logic [WIDTH_W-1:0]   col_a;
    logic [HEIGHT_W:0]    row_a;
    logic [COL_W-1:0]     cur_col;
    logic [HEIGHT_W-1:0]  cur_row;
    logic [WIDTH_W-1:0]   col_p1;
    logic [HEIGHT_W:0]    row_p1;
    logic [COL_W-1:0]     n_col;
    logic [HEIGHT_W-1:0]  n_row;
    logic                 cur_emit;
    logic                 cur_last;
    logic [PIX_W-1:0]     new_top;
    logic [PIX_W-1:0]     new_mid;
    logic [GRAD_W-1:0]    ax;
    logic [GRAD_W-1:0]    ay;
    logic                 pipe_valid;

    function automatic logic [GRAD_W-1:0] kernel_sum(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b,
                                                     input logic [PIX_W-1:0] c);
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] p,
                                                   input logic [GRAD_W-1:0] q);
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    assign advance    = !(o_out_valid && i_out_stall);
    assign accept     = i_in_valid && !r_busy;
    assign do_update  = r_busy && advance;
    assign o_in_stall = r_busy;

    // effective frame size
    always_comb begin
        if (r_cfg_width < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (r_cfg_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_cfg_width;
        end
        h_eff = (r_cfg_height < HEIGHT_MIN) ? HEIGHT_MIN : r_cfg_height;
    end

    // position of the incoming pixel and of the one after it
    always_comb begin
        col_a = i_frame_start ? '0 : {{(WIDTH_W-COL_W){1'b0}}, r_col};
        row_a = i_frame_start ? '0 : {1'b0, r_row};
        // counters left past a shrunk frame size
        if (col_a >= w_eff) begin
            col_a = '0;
            row_a = row_a + 1'b1;
        end
        if (row_a >= {1'b0, h_eff}) begin
            row_a = '0;
        end
        cur_col = col_a[COL_W-1:0];
        cur_row = row_a[HEIGHT_W-1:0];

        col_p1 = {{(WIDTH_W-COL_W){1'b0}}, cur_col} + 1'b1;
        row_p1 = {1'b0, cur_row} + 1'b1;
        if (col_p1 >= w_eff) begin
            n_col = '0;
            n_row = (row_p1 >= {1'b0, h_eff}) ? '0 : row_p1[HEIGHT_W-1:0];
        end else begin
            n_col = col_p1[COL_W-1:0];
            n_row = cur_row;
        end

        cur_emit = (cur_col >= COL_W'(2)) && (cur_row >= HEIGHT_W'(2));
        cur_last = ({{(WIDTH_W-COL_W){1'b0}}, cur_col} == w_eff - 1'b1)
                && (cur_row == h_eff - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // acceptance: counters move on, read is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_busy <= 1'b0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_busy <= 1'b1;
        end else if (do_update) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px   <= i_pixel;
            r_addr <= cur_col;
            r_emit <= cur_emit;
            r_last <= cur_last;
        end
    end

    // line memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_line_mem[cur_col];
        end
        if (do_update) begin
            r_line_mem[r_addr] <= {r_rd_data[PIX_W-1:0], r_px};
        end
    end

    assign new_top = r_rd_data[2*PIX_W-1:PIX_W];
    assign new_mid = r_rd_data[PIX_W-1:0];

    // gradients over the window after this shift
    always_comb begin
        ax = abs_diff(kernel_sum(new_top, new_mid, r_px),
                      kernel_sum(r_win[0][1], r_win[1][1], r_win[2][1]));
        ay = abs_diff(kernel_sum(r_win[2][1], r_win[2][2], r_px),
                      kernel_sum(r_win[0][1], r_win[0][2], new_top));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (do_update) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= new_top;
            r_win[1][2] <= new_mid;
            r_win[2][2] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grad.vld <= 1'b0;
        end else if (advance) begin
            r_grad.vld  <= do_update && r_emit;
            r_grad.ax   <= ax;
            r_grad.ay   <= ay;
            r_grad.last <= r_last;
        end
    end

    sem_mag_pipe u_mag_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_grad      (r_grad),
        .o_valid     (pipe_valid),
        .o_magnitude (o_magnitude),
        .o_last      (o_last_of_frame)
    );

    assign o_out_valid = pipe_valid;

endmodule

FILE: rtl/sem_checker.sv
// Port-level checks for the Sobel magnitude unit, bound to the top level.
module sem_checker
    import sem_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [ROOT_W-1:0] o_magnitude,
    input logic              o_last_of_frame
);

    // input held off in the cycle after every accepted pixel, for its memory write-back
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off during write-back");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_magnitude) && $stable(o_last_of_frame)))
        else $error("stalled output word changed");

endmodule

bind sobel_edge_magnitude_3x3_unit sem_checker u_sem_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_magnitude     (o_magnitude),
    .o_last_of_frame (o_last_of_frame)
);

FILE: verif/sobel_edge_magnitude_3x3_unit_tb.sv
// Self-checking testbench for the 3x3 Sobel edge magnitude unit: directed frames, random streams.
module sobel_edge_magnitude_3x3_unit_tb
    import sem_pkg::*;
();

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 8;
    localparam int DRAIN_CYCLES  = 24;          // margin for the result pipe to drain
    localparam int RANDOM_PIXELS = 1250;
    localparam int WIDE_LEAD     = 2 * MAX_WIDTH + 40;
    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int MAG_SAT       = 255;

    // pixel content of a frame
    typedef enum int {
        TEX_NOISE,
        TEX_FLAT,
        TEX_BINARY,
        TEX_DARK
    } t_texture;

    typedef struct packed {
        logic [ROOT_W-1:0] mag;
        logic              last;
    } t_edge_word;

    typedef struct packed {
        logic [PIX_W-1:0]  px;
        logic              fs;
        logic              typed;
        logic [ROOT_W-1:0] mag;
        logic              last;
    } t_pixel_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [PIX_W-1:0]       i_pixel       = '0;
    logic                   i_frame_start = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [ROOT_W-1:0]      o_magnitude;
    logic                   o_last_of_frame;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    sobel_edge_magnitude_3x3_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel         (i_pixel),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_magnitude     (o_magnitude),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Directed frames, all at 3x3 so each frame gives exactly one (last) word.
    localparam int DIRECTED_ROWS = 27;
    t_pixel_row directed_rows [DIRECTED_ROWS] = '{
        // dark left columns, bright right column: gx = 4 * 255, clipped to 255
        '{8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
        // flat white: no gradient at all
        '{8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b1, 8'd0,   1'b1},
        // no frame start: counters wrap on their own after the last pixel
        '{8'd3,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd4,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd5,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd9,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd2,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd6,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd5,   1'b0, 1'b0, 8'd0,   1'b0}
    };

    t_edge_word expected_edges [$];
    int         error_count = 0;
    int         pixels_sent = 0;
    bit         no_idle     = 1'b0;

    // Predictor state: registers, two line stores, window, position.
    logic [WIDTH_W-1:0]  mdl_width_reg;
    logic [HEIGHT_W-1:0] mdl_height_reg;
    logic [PIX_W-1:0]    row_above     [MAX_WIDTH];
    logic [PIX_W-1:0]    row_two_above [MAX_WIDTH];
    logic [PIX_W-1:0]    win [3][3];
    int unsigned         cur_col;
    int unsigned         cur_row;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int unsigned active_width();
        int unsigned w;
        w = mdl_width_reg;
        if (w < WIDTH_MIN) w = WIDTH_MIN;
        if (w > WIDTH_MAX) w = WIDTH_MAX;
        return w;
    endfunction

    function automatic int unsigned active_height();
        return (mdl_height_reg < HEIGHT_MIN) ? HEIGHT_MIN : mdl_height_reg;
    endfunction

    function automatic logic [ROOT_W-1:0] edge_root(input int unsigned sum);
        int unsigned r;
        if (sum >= 65536) return ROOT_W'(MAG_SAT);
        r = 0;
        while ((r + 1) * (r + 1) <= sum) r++;
        return ROOT_W'(r);
    endfunction

    // Advance the predictor by one pixel; returns 1 when the pixel closes an interior window.
    function automatic bit sobel_step(input logic [PIX_W-1:0] px, input logic fs,
                                      output t_edge_word word);
        int unsigned w, h, c, r;
        int          gx, gy;
        bit          produces;
        w = active_width();
        h = active_height();
        if (fs) begin
            cur_col = 0;
            cur_row = 0;
        end
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        c = cur_col;
        r = cur_row;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]        = row_two_above[c];
        win[1][2]        = row_above[c];
        win[2][2]        = px;
        row_two_above[c] = row_above[c];
        row_above[c]     = px;
        word     = '0;
        produces = (c >= 2) && (r >= 2);
        if (produces) begin
            gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
            gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
            word.mag  = edge_root(int'(gx * gx + gy * gy));
            word.last = (c == w - 1) && (r == h - 1);
        end
        cur_col = c + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = r + 1;
            if (cur_row >= h) cur_row = 0;
        end
        return produces;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input t_texture tex, input int base);
        int v;
        case (tex)
            TEX_NOISE:  return PIX_W'($urandom);
            TEX_FLAT: begin
                v = base + int'($urandom_range(0, 15)) - 8;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return PIX_W'(v);
            end
            TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:    return PIX_W'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Sender: random gap, then hold the word until it is taken. Valid is only
    // dropped when a gap follows, so back-to-back words keep it high.
    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs,
                              input logic typed, input t_edge_word typed_word);
        int         gap;
        t_edge_word word;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel       <= px;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pixels_sent++;
        if (sobel_step(px, fs, word)) expected_edges.push_back(typed ? typed_word : word);
    endtask

    // Stop sending, let every expected word out, then let trailing pixels clear the pipe.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [CFG_DATA_W-1:0] width_data,
                              input logic [CFG_DATA_W-1:0] height_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= width_data;
        @(posedge i_clk);
        mdl_width_reg = width_data[WIDTH_W-1:0];
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= height_data;
        @(posedge i_clk);
        mdl_height_reg = height_data;
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_edge_word();
        t_edge_word want;
        if (expected_edges.size() == 0) begin
            report_mismatch($sformatf("unexpected word mag=%0d last=%0b",
                                      o_magnitude, o_last_of_frame));
            return;
        end
        want = expected_edges.pop_front();
        if (o_magnitude !== want.mag)
            report_mismatch($sformatf("magnitude got %0d want %0d", o_magnitude, want.mag));
        if (o_last_of_frame !== want.last)
            report_mismatch($sformatf("last_of_frame got %0b want %0b",
                                      o_last_of_frame, want.last));
    endtask

    // One random phase: new dimensions, then mostly whole frames with random
    // content; some frames cut short, some without a start flag, rare stray starts.
    task automatic run_phase();
        logic [CFG_DATA_W-1:0] wd, hd;
        int unsigned           w, h, frames, len;
        t_texture              tex;
        int                    base;
        bit                    fresh, lead;
        case ($urandom_range(0, 9))
            0:       wd = CFG_DATA_W'($urandom_range(0, 2));
            1:       wd = {5'($urandom), 11'($urandom_range(3, 12))};
            2:       wd = CFG_DATA_W'($urandom_range(13, 40));
            default: wd = CFG_DATA_W'($urandom_range(3, 10));
        endcase
        case ($urandom_range(0, 9))
            0:       hd = CFG_DATA_W'($urandom_range(0, 2));
            1:       hd = 16'hFFFF;
            2:       hd = CFG_DATA_W'($urandom_range(9, 14));
            default: hd = CFG_DATA_W'($urandom_range(3, 7));
        endcase
        settle();
        write_dims(wd, hd);
        no_idle = ($urandom_range(0, 3) == 0);
        w       = active_width();
        h       = active_height();
        // a phase without a leading start resumes wherever the counters stand
        fresh   = ($urandom_range(0, 4) != 0);
        if (h > 64) begin
            len = $urandom_range(40, 90);
            for (int i = 0; i < len; i++)
                push_pixel(pick_pixel(TEX_NOISE, 0), fresh && (i == 0), 1'b0, '0);
        end else begin
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                tex  = t_texture'($urandom_range(0, 3));
                base = $urandom_range(0, 255);
                lead = (f == 0) ? fresh : ($urandom_range(0, 5) != 0);
                len  = w * h;
                if ($urandom_range(0, 7) == 0) len = $urandom_range(1, w * h - 1);
                for (int i = 0; i < len; i++)
                    push_pixel(pick_pixel(tex, base),
                               (lead && (i == 0)) || ($urandom_range(0, 199) == 0),
                               1'b0, '0);
            end
        end
    endtask

    // Receiver: after each taken word draw a stall length; phases without idling draw none.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                check_edge_word();
                hold = no_idle ? 0 : $urandom_range(0, 19);
            end else if (hold > 0) begin
                hold--;
            end
            i_out_stall <= (hold > 0);
        end
    end

    initial begin
        int random_start;
        mdl_width_reg  = WIDTH_RESET;
        mdl_height_reg = HEIGHT_RESET;
        cur_col        = 0;
        cur_row        = 0;
        foreach (row_above[i]) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest legal image for the directed frames
        write_dims(CFG_DATA_W'(3), CFG_DATA_W'(3));
        foreach (directed_rows[i])
            push_pixel(directed_rows[i].px, directed_rows[i].fs, directed_rows[i].typed,
                       t_edge_word'({directed_rows[i].mag, directed_rows[i].last}));

        // Widest image, three rows. Paused mid-way through the last row and the
        // width rewritten as 2047, which must clamp to the same line length.
        // This also leaves every column of both line stores written.
        settle();
        write_dims(CFG_DATA_W'(MAX_WIDTH), CFG_DATA_W'(3));
        for (int i = 0; i < WIDE_LEAD; i++)
            push_pixel(pick_pixel(t_texture'((i >> 6) % 4), 128), i == 0, 1'b0, '0);
        settle();
        write_dims(16'h07FF, CFG_DATA_W'(3));
        for (int i = WIDE_LEAD; i < 3 * MAX_WIDTH; i++)
            push_pixel(pick_pixel(t_texture'((i >> 6) % 4), 128), 1'b0, 1'b0, '0);

        random_start = pixels_sent;
        while (pixels_sent < random_start + RANDOM_PIXELS) run_phase();

        settle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

endmodule
